FILE: rtl/bba_pkg.sv
// bba_pkg: shared types and codes for the buddy block allocator
// depends on nothing; imported by the allocator core and its checker
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    // item modes
    localparam logic [1:0] MODE_REBUILD = 2'd0;
    localparam logic [1:0] MODE_ALLOC   = 2'd1;
    localparam logic [1:0] MODE_FREE    = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ZERO    = 2'd1;
    localparam logic [1:0] STAT_TOO_BIG = 2'd2;
    localparam logic [1:0] STAT_NO_FREE = 2'd3;

    // order map code for an entry that is not a free block head
    localparam logic [4:0] NOT_HEAD = 5'd0;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RB_PUSH,
        ST_AL_SRCH,
        ST_AL_RD,
        ST_AL_UPD,
        ST_AL_SPLIT,
        ST_FR_RD,
        ST_FR_CHK,
        ST_M_CHK,
        ST_M_RD,
        ST_W_LOOP,
        ST_W_WAIT,
        ST_U_BUD,
        ST_PUSH,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/bba_ram.sv
// bba_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/buddy_block_allocator_core.sv
// buddy_block_allocator_core: buddy allocator with per-order lifo free lists
// depends on bba_pkg and bba_ram (one block-entry memory)
`timescale 1ns / 1ps
`default_nettype none

// Buddy allocator over minimum-size blocks. Items are taken with start while busy is
// low; each item gives one result word on the done strobe, which cannot be held off.
// All per-block state (head order, granted order, list link) sits in one ram with a
// registered read, walked by a sequencer. A rebuild clears that ram one entry a cycle,
// all 2^(POOL_ORDER-MIN_ORDER) entries (8192 by default), then pushes at most a few
// top-order blocks; the same clearing pass runs after reset, with busy high. An
// allocate unlinks the smallest free block that fits and splits it once per order
// above the order asked for; a free checks the granted order, then per merge reads
// the buddy and walks its list to unlink it, until the buddy is not a free head.
// Zero-size, oversized, malformed or unused-mode items, an allocate that finds no
// free block and a free of a block that is not granted end early.
module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MIN_ORDER     = 5,
    parameter int LARGEST_ORDER = 16,
    parameter int POOL_ORDER    = 18,
    parameter int HEADER_BYTES  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [19:0] req_bytes,
    input  wire logic [17:0] free_offset,
    output logic             done,
    output logic [1:0]       status,
    output logic [17:0]      user_offset,
    output logic [18:0]      free_total,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [18:0] cfg_data
);

    localparam int IDX_W  = POOL_ORDER - MIN_ORDER;
    localparam int BLOCKS = 1 << IDX_W;
    localparam int NLISTS = LARGEST_ORDER - MIN_ORDER + 1;
    localparam int LIST_W = (NLISTS > 1) ? $clog2(NLISTS) : 1;
    localparam int LW     = IDX_W + 1;
    localparam int WW     = LW + 10;
    localparam int FREE_W = POOL_ORDER + 1;
    localparam logic [LW-1:0] NIL = {1'b1, {IDX_W{1'b0}}};

    state_t state_reg, state_next;

    logic [18:0]       pool_reg;
    logic [LW-1:0]     head_reg [NLISTS];
    logic [FREE_W-1:0] free_reg;
    logic [IDX_W:0]    used_reg;
    logic [IDX_W:0]    sweep_reg;
    logic [IDX_W:0]    off_reg;
    logic              rb_reg;
    logic [4:0]        top_reg;
    logic [4:0]        ord_reg;
    logic [4:0]        o_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  bidx_reg;
    logic [LW-1:0]     cur_reg;
    logic [LW-1:0]     prev_reg;
    logic [LW-1:0]     blink_reg;
    logic [1:0]        stat_reg;
    logic [17:0]       uoff_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WW-1:0]     ram_rdata;

    function automatic logic [LIST_W-1:0] lidx(input logic [4:0] o);
        logic [4:0] d;
        d = o - 5'(MIN_ORDER);
        return d[LIST_W-1:0];
    endfunction

    function automatic logic [WW-1:0] mk(input logic [4:0] h, input logic [4:0] g,
                                         input logic [LW-1:0] l);
        return {h, g, l};
    endfunction

    bba_ram #(
        .WIDTH(WW),
        .DEPTH(BLOCKS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // read data fields
    logic [4:0]    rd_hmap;
    logic [4:0]    rd_gnt;
    logic [LW-1:0] rd_link;
    assign rd_link = ram_rdata[LW-1:0];
    assign rd_gnt  = ram_rdata[LW+4:LW];
    assign rd_hmap = ram_rdata[LW+9:LW+5];

    logic accept;
    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // item decode and shared datapath terms
    logic [31:0]       size32, usable32, fo32, boff32, fidx32, sweep_end32;
    logic [4:0]        ord_c, top_c, fnd_o, no_c;
    logic              ord_ok, fr_ok, fnd_ok, sweep_last, rb_more, split_more;
    logic [IDX_W:0]    used_c;
    logic [IDX_W+1:0]  rb_sum;
    logic [IDX_W-1:0]  split_idx, bud_idx, fidx_c;
    logic [LIST_W-1:0] ord_l;
    logic [FREE_W-1:0] o_bytes, no_bytes;
    always_comb
    begin
        size32 = 32'(req_bytes) + 32'(HEADER_BYTES);
        ord_c  = 5'(LARGEST_ORDER);
        ord_ok = 1'b0;
        for (int o = LARGEST_ORDER; o >= MIN_ORDER; o--)
        begin
            if ((32'(1) << o) >= size32)
            begin
                ord_c  = 5'(o);
                ord_ok = 1'b1;
            end
        end

        usable32 = 32'(pool_reg) & ~((32'(1) << MIN_ORDER) - 32'(1));
        if (usable32 > (32'(1) << POOL_ORDER))
        begin
            usable32 = 32'(1) << POOL_ORDER;
        end
        usable32 = usable32 >> MIN_ORDER;
        used_c   = usable32[IDX_W:0];

        fo32   = 32'(free_offset);
        boff32 = fo32 - 32'(HEADER_BYTES);
        fidx32 = boff32 >> MIN_ORDER;
        fidx_c = fidx32[IDX_W-1:0];
        fr_ok  = (fo32 >= 32'(HEADER_BYTES)) && (boff32[MIN_ORDER-1:0] == '0) &&
                 (fidx32 < 32'(BLOCKS));

        top_c = 5'(MIN_ORDER);
        for (int o = MIN_ORDER; o <= LARGEST_ORDER; o++)
        begin
            if ((32'(1) << (o - MIN_ORDER)) <= 32'(used_reg))
            begin
                top_c = 5'(o);
            end
        end

        ord_l  = lidx(ord_reg);
        fnd_ok = 1'b0;
        fnd_o  = 5'(MIN_ORDER);
        for (int l = NLISTS - 1; l >= 0; l--)
        begin
            if (!head_reg[l][LW-1] && (LIST_W'(l) >= ord_l))
            begin
                fnd_ok = 1'b1;
                fnd_o  = 5'(l + MIN_ORDER);
            end
        end

        sweep_end32 = 32'(BLOCKS - 1);
        sweep_last  = (sweep_reg[IDX_W-1:0] == sweep_end32[IDX_W-1:0]);
        rb_sum      = {1'b0, off_reg} +
                      ((IDX_W + 2)'(1) << (top_reg - 5'(MIN_ORDER)));
        rb_more     = (rb_sum <= {1'b0, used_reg});

        no_c       = o_reg - 5'd1;
        split_more = (o_reg > ord_reg);
        split_idx  = idx_reg + (IDX_W'(1) << (no_c - 5'(MIN_ORDER)));
        bud_idx    = idx_reg ^ (IDX_W'(1) << (o_reg - 5'(MIN_ORDER)));
        o_bytes    = FREE_W'(1) << o_reg;
        no_bytes   = FREE_W'(1) << no_c;
    end

    logic gnt_ok, merge_go, hit_bud;
    assign gnt_ok   = (rd_gnt >= 5'(MIN_ORDER)) && (rd_gnt <= 5'(LARGEST_ORDER));
    assign merge_go = (o_reg < 5'(LARGEST_ORDER)) && ({1'b0, bud_idx} < used_reg);
    assign hit_bud  = (cur_reg == {1'b0, bidx_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_REBUILD: state_next = ST_SWEEP;
                        MODE_ALLOC:
                        begin
                            if (req_bytes == '0 || !ord_ok) state_next = ST_DONE;
                            else                            state_next = ST_AL_SRCH;
                        end
                        MODE_FREE: state_next = fr_ok ? ST_FR_RD : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last) state_next = rb_reg ? ST_RB_PUSH : ST_IDLE;
            end
            ST_RB_PUSH:  if (!rb_more) state_next = ST_DONE;
            ST_AL_SRCH:  state_next = fnd_ok ? ST_AL_RD : ST_DONE;
            ST_AL_RD:    state_next = ST_AL_UPD;
            ST_AL_UPD:   state_next = ST_AL_SPLIT;
            ST_AL_SPLIT: if (!split_more) state_next = ST_DONE;
            ST_FR_RD:    state_next = ST_FR_CHK;
            ST_FR_CHK:   state_next = gnt_ok ? ST_M_CHK : ST_DONE;
            ST_M_CHK:    state_next = merge_go ? ST_M_RD : ST_PUSH;
            ST_M_RD:     state_next = (rd_hmap == o_reg) ? ST_W_LOOP : ST_PUSH;
            ST_W_LOOP:
            begin
                if (cur_reg[LW-1]) state_next = ST_PUSH;
                else if (hit_bud)  state_next = ST_U_BUD;
                else               state_next = ST_W_WAIT;
            end
            ST_W_WAIT:   state_next = ST_W_LOOP;
            ST_U_BUD:    state_next = ST_M_CHK;
            ST_PUSH:     state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory port control and strobe
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        done      = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg[IDX_W-1:0];
                ram_wdata = mk(NOT_HEAD, 5'd0, '0);
            end
            ST_RB_PUSH:
            begin
                ram_we    = rb_more;
                ram_waddr = off_reg[IDX_W-1:0];
                ram_wdata = mk(top_reg, 5'd0, head_reg[lidx(top_reg)]);
            end
            ST_AL_RD: ram_raddr = idx_reg;
            ST_AL_UPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = mk(NOT_HEAD, ord_reg, '0);
            end
            ST_AL_SPLIT:
            begin
                ram_we    = split_more;
                ram_waddr = split_idx;
                ram_wdata = mk(no_c, 5'd0, head_reg[lidx(no_c)]);
            end
            ST_FR_RD: ram_raddr = idx_reg;
            ST_FR_CHK:
            begin
                ram_we    = gnt_ok;
                ram_waddr = idx_reg;
                ram_wdata = mk(NOT_HEAD, 5'd0, '0);
            end
            ST_M_CHK: ram_raddr = bud_idx;
            ST_W_LOOP:
            begin
                ram_raddr = cur_reg[IDX_W-1:0];
                if (!cur_reg[LW-1] && hit_bud && !prev_reg[LW-1])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_reg[IDX_W-1:0];
                    ram_wdata = mk(o_reg, 5'd0, blink_reg);
                end
            end
            ST_U_BUD:
            begin
                ram_we    = 1'b1;
                ram_waddr = bidx_reg;
                ram_wdata = mk(NOT_HEAD, 5'd0, '0);
            end
            ST_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = mk(o_reg, 5'd0, head_reg[lidx(o_reg)]);
            end
            ST_DONE: done = 1'b1;
            default: ;
        endcase
    end

    // sequencer registers and list heads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            pool_reg  <= 19'd262144;
            for (int l = 0; l < NLISTS; l++)
            begin
                head_reg[l] <= NIL;
            end
            free_reg  <= '0;
            used_reg  <= '0;
            sweep_reg <= '0;
            off_reg   <= '0;
            rb_reg    <= 1'b0;
            top_reg   <= 5'(MIN_ORDER);
            ord_reg   <= 5'(MIN_ORDER);
            o_reg     <= 5'(MIN_ORDER);
            idx_reg   <= '0;
            bidx_reg  <= '0;
            cur_reg   <= NIL;
            prev_reg  <= NIL;
            blink_reg <= NIL;
            stat_reg  <= STAT_OK;
            uoff_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                pool_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        uoff_reg <= '0;
                        if (mode == MODE_ALLOC && req_bytes == '0)
                        begin
                            stat_reg <= STAT_ZERO;
                        end
                        else if (mode == MODE_ALLOC && !ord_ok)
                        begin
                            stat_reg <= STAT_TOO_BIG;
                        end
                        else
                        begin
                            stat_reg <= STAT_OK;
                        end
                        case (mode)
                            MODE_REBUILD:
                            begin
                                sweep_reg <= '0;
                                rb_reg    <= 1'b1;
                                used_reg  <= used_c;
                                free_reg  <= '0;
                                for (int l = 0; l < NLISTS; l++)
                                begin
                                    head_reg[l] <= NIL;
                                end
                            end
                            MODE_ALLOC: ord_reg <= ord_c;
                            MODE_FREE:  idx_reg <= fidx_c;
                            default: ;
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + (IDX_W + 1)'(1);
                    off_reg   <= '0;
                    top_reg   <= top_c;
                end
                ST_RB_PUSH:
                begin
                    rb_reg <= 1'b0;
                    if (rb_more)
                    begin
                        head_reg[lidx(top_reg)] <= off_reg;
                        free_reg <= free_reg + (FREE_W'(1) << top_reg);
                        off_reg  <= rb_sum[IDX_W:0];
                    end
                end
                ST_AL_SRCH:
                begin
                    if (fnd_ok)
                    begin
                        o_reg   <= fnd_o;
                        idx_reg <= head_reg[lidx(fnd_o)][IDX_W-1:0];
                    end
                    else
                    begin
                        stat_reg <= STAT_NO_FREE;
                    end
                end
                ST_AL_UPD:
                begin
                    head_reg[lidx(o_reg)] <= rd_link;
                    free_reg <= free_reg - o_bytes;
                end
                ST_AL_SPLIT:
                begin
                    if (split_more)
                    begin
                        o_reg <= no_c;
                        head_reg[lidx(no_c)] <= {1'b0, split_idx};
                        free_reg <= free_reg + no_bytes;
                    end
                    else
                    begin
                        uoff_reg <= 18'((32'(idx_reg) << MIN_ORDER) + 32'(HEADER_BYTES));
                    end
                end
                ST_FR_CHK: o_reg <= rd_gnt;
                ST_M_CHK:  bidx_reg <= bud_idx;
                ST_M_RD:
                begin
                    cur_reg   <= head_reg[lidx(o_reg)];
                    prev_reg  <= NIL;
                    blink_reg <= rd_link;
                end
                ST_W_LOOP:
                begin
                    if (!cur_reg[LW-1] && hit_bud && prev_reg[LW-1])
                    begin
                        head_reg[lidx(o_reg)] <= blink_reg;
                    end
                end
                ST_W_WAIT:
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= rd_link;
                end
                ST_U_BUD:
                begin
                    free_reg <= free_reg - o_bytes;
                    o_reg    <= o_reg + 5'd1;
                    if (bidx_reg < idx_reg)
                    begin
                        idx_reg <= bidx_reg;
                    end
                end
                ST_PUSH:
                begin
                    head_reg[lidx(o_reg)] <= {1'b0, idx_reg};
                    free_reg <= free_reg + o_bytes;
                end
                default: ;
            endcase
        end
    end

    // result word
    logic [31:0] free32;
    assign free32      = 32'(free_reg);
    assign status      = stat_reg;
    assign user_offset = uoff_reg;
    assign free_total  = free32[18:0];

endmodule

`default_nettype wire

FILE: rtl/bba_checker.sv
// bba_checker: port-level assertions for the buddy allocator core
// depends on bba_pkg; bound to buddy_block_allocator_core
`timescale 1ns / 1ps
`default_nettype none

module bba_checker
    import bba_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [17:0] user_offset,
    input wire logic [18:0] free_total
);

    // an accepted word keeps the core busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // a result word only appears while busy, and frees the core right after
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("core still busy after result");

    // failed requests carry no offset
    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (user_offset == '0))
        else $error("nonzero offset on failed request");

    // free byte count only moves while an item is in flight
    a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && $past(!busy)) |-> $stable(free_total))
        else $error("free byte count changed while idle");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// testbench: self-checking bench for buddy_block_allocator_core
// depends on bba_pkg and the allocator core; holds its own allocator predictor
`timescale 1ns / 1ps

module testbench;
    import bba_pkg::*;

    localparam int LO_ORD    = 5;
    localparam int HI_ORD    = 16;
    localparam int POOL_ORD  = 18;
    localparam int HDR       = 8;
    localparam int NBLK      = 1 << (POOL_ORD - LO_ORD);
    localparam int NLIST     = HI_ORD - LO_ORD + 1;
    localparam int unsigned EMPTY = 32'hFFFF_FFFF;
    localparam logic [7:0] NO_HEAD = 8'hFF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] uoff;
        logic [18:0] total;
    } alloc_word_t;

    // allocator predictor and store of expected result words
    class alloc_scoreboard;
        logic [7:0]  head_ord [NBLK];
        int unsigned grant_ord [NBLK];
        int unsigned link [NBLK];
        int unsigned heads [NLIST];
        int unsigned free_bytes;
        int unsigned pool;
        int unsigned nblocks;
        alloc_word_t awaited[$];
        int          errors;

        function new();
            wipe();
            pool = 262144;
            errors = 0;
        endfunction

        function void wipe();
            for (int i = 0; i < NBLK; i++)
            begin
                head_ord[i] = NO_HEAD;
                grant_ord[i] = 0;
                link[i] = 0;
            end
            for (int i = 0; i < NLIST; i++)
                heads[i] = EMPTY;
            free_bytes = 0;
            nblocks = 0;
        endfunction

        function void push_blk(int unsigned ord, int unsigned idx);
            link[idx] = heads[ord - LO_ORD];
            heads[ord - LO_ORD] = idx;
            head_ord[idx] = ord[7:0];
            free_bytes += 1 << ord;
        endfunction

        function bit unlink_blk(int unsigned ord, int unsigned idx);
            int unsigned prev;
            int unsigned cur;
            int unsigned guard;
            prev = EMPTY;
            cur = heads[ord - LO_ORD];
            guard = 0;
            while (cur != EMPTY && cur < NBLK && guard <= NBLK)
            begin
                if (cur == idx)
                begin
                    if (prev == EMPTY)
                        heads[ord - LO_ORD] = link[cur];
                    else
                        link[prev] = link[cur];
                    head_ord[idx] = NO_HEAD;
                    free_bytes -= 1 << ord;
                    return 1;
                end
                prev = cur;
                cur = link[cur];
                guard++;
            end
            return 0;
        endfunction

        function void set_pool(logic [18:0] v);
            pool = v;
        endfunction

        // note an accepted item, queue its expected word, hand back the grant
        function int unsigned note_item(logic [1:0] m, logic [19:0] req, logic [17:0] fo);
            alloc_word_t w;
            int unsigned usable, top, off, sz, ord, found, idx, o, boff, bidx;
            w.status = STAT_OK;
            w.uoff = '0;
            if (m == MODE_REBUILD)
            begin
                usable = pool & ~((1 << LO_ORD) - 1);
                wipe();
                if (usable > (1 << POOL_ORD))
                    usable = 1 << POOL_ORD;
                nblocks = usable >> LO_ORD;
                top = HI_ORD;
                while (top > LO_ORD && (1 << top) > usable)
                    top--;
                off = 0;
                while (off + (1 << top) <= usable)
                begin
                    push_blk(top, off >> LO_ORD);
                    off += 1 << top;
                end
            end
            else if (m == MODE_ALLOC)
            begin
                sz = req;
                if (sz == 0)
                    w.status = STAT_ZERO;
                else
                begin
                    sz += HDR;
                    ord = LO_ORD;
                    while (ord <= HI_ORD && (1 << ord) < sz)
                        ord++;
                    if (ord > HI_ORD)
                        w.status = STAT_TOO_BIG;
                    else
                    begin
                        found = ord;
                        while (found <= HI_ORD && heads[found - LO_ORD] == EMPTY)
                            found++;
                        if (found > HI_ORD)
                            w.status = STAT_NO_FREE;
                        else
                        begin
                            idx = heads[found - LO_ORD];
                            o = found;
                            void'(unlink_blk(found, idx));
                            while (o > ord)
                            begin
                                o--;
                                push_blk(o, idx + ((1 << o) >> LO_ORD));
                            end
                            head_ord[idx] = NO_HEAD;
                            grant_ord[idx] = ord;
                            w.uoff = 18'((idx << LO_ORD) + HDR);
                        end
                    end
                end
            end
            else if (m == MODE_FREE && fo >= HDR)
            begin
                boff = fo - HDR;
                idx = boff >> LO_ORD;
                if ((boff & ((1 << LO_ORD) - 1)) == 0 && idx < NBLK &&
                    grant_ord[idx] >= LO_ORD && grant_ord[idx] <= HI_ORD)
                begin
                    ord = grant_ord[idx];
                    grant_ord[idx] = 0;
                    // merge upward while the buddy is a free head of the same order
                    while (ord < HI_ORD)
                    begin
                        bidx = ((idx << LO_ORD) ^ (1 << ord)) >> LO_ORD;
                        if (bidx >= nblocks)
                            break;
                        if (head_ord[bidx] != ord[7:0])
                            break;
                        if (!unlink_blk(ord, bidx))
                            break;
                        if (bidx < idx)
                            idx = bidx;
                        ord++;
                    end
                    push_blk(ord, idx);
                end
            end
            w.total = 19'(free_bytes);
            awaited.push_back(w);
            return w.uoff;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        // compare one result word with the oldest expectation
        task check_word(logic [1:0] st, logic [17:0] uo, logic [18:0] tot);
            alloc_word_t w;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected word st=%0d off=%0d total=%0d", st, uo, tot));
                return;
            end
            w = awaited.pop_front();
            if (st !== w.status)
                report($sformatf("status got %0d want %0d", st, w.status));
            if (uo !== w.uoff)
                report($sformatf("user_offset got %0d want %0d", uo, w.uoff));
            if (tot !== w.total)
                report($sformatf("free_total got %0d want %0d", tot, w.total));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [19:0] req_bytes;
    logic [17:0] free_offset;
    logic        done;
    logic [1:0]  status;
    logic [17:0] user_offset;
    logic [18:0] free_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [18:0] cfg_data;

    alloc_scoreboard sb;
    int unsigned live[$];
    int unsigned released[$];
    int          idle_cycles;
    bit          no_gaps;

    buddy_block_allocator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .req_bytes   (req_bytes),
        .free_offset (free_offset),
        .done        (done),
        .status      (status),
        .user_offset (user_offset),
        .free_total  (free_total),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(status, user_offset, free_total);
    end

    // watchdog on cycles with no accepted word in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[buddy_block_allocator_core] ERROR");
            $finish;
        end
    end

    // issue one item and wait for it to be taken
    task send_item(logic [1:0] m, logic [19:0] req, logic [17:0] fo);
        int gap;
        int unsigned g;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        req_bytes <= req;
        free_offset <= fo;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        g = sb.note_item(m, req, fo);
        if (m == MODE_REBUILD)
        begin
            live.delete();
            released.delete();
        end
        if (m == MODE_ALLOC && g != 0)
            live.push_back(g);
    endtask

    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the core idle
    task write_pool(logic [18:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_pool(v);
    endtask

    task free_live(int k);
        int unsigned o;
        o = live[k];
        live.delete(k);
        released.push_back(o);
        send_item(MODE_FREE, 20'($urandom), o[17:0]);
    endtask

    task random_item();
        int k;
        logic [19:0] sz;
        k = $urandom_range(0, 99);
        if (k < 52 || (k < 85 && live.size() == 0))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: sz = 20'($urandom_range(1, 200));
                6, 7:             sz = 20'($urandom_range(1, 4000));
                8:                sz = 20'($urandom_range(1, 65528));
                default:          sz = 20'($urandom_range(0, 1048575));
            endcase
            send_item(MODE_ALLOC, sz, 18'($urandom));
        end
        else if (k < 85)
            free_live($urandom_range(0, live.size() - 1));
        else if (k < 90 && released.size() != 0)
            send_item(MODE_FREE, 20'($urandom),
                      18'(released[$urandom_range(0, released.size() - 1)]));
        else if (k < 95)
            send_item(MODE_FREE, 20'($urandom), 18'($urandom));
        else if (k < 98)
            send_item(MODE_UNUSED, 20'($urandom), 18'($urandom));
        else
            send_item(MODE_ALLOC, 20'd0, 18'($urandom));
    endtask

    logic [18:0] pool_set[9];

    initial
    begin
        sb = new();
        no_gaps = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_REBUILD;
        req_bytes = '0;
        free_offset = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // let the clearing pass after reset finish
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed: edge sizes, bad frees, exhaustion and coalescing
        send_item(MODE_ALLOC, 20'd100, '0);
        send_item(MODE_REBUILD, '1, '0);
        send_item(MODE_ALLOC, 20'd1, '0);
        send_item(MODE_ALLOC, 20'd0, '0);
        send_item(MODE_ALLOC, 20'd65529, '0);
        send_item(MODE_ALLOC, 20'hFFFFF, '1);
        send_item(MODE_ALLOC, 20'd65528, '0);
        send_item(MODE_ALLOC, 20'd65528, '0);
        send_item(MODE_ALLOC, 20'd65528, '0);
        send_item(MODE_ALLOC, 20'd24, '0);
        send_item(MODE_FREE, '0, 18'd0);
        send_item(MODE_FREE, '0, 18'd7);
        send_item(MODE_FREE, '0, 18'd9);
        send_item(MODE_FREE, '0, 18'h3FFFF);
        send_item(MODE_UNUSED, '1, '1);
        while (live.size() != 0)
            free_live(live.size() - 1);
        send_item(MODE_FREE, '0, released[0][17:0]);
        send_item(MODE_ALLOC, 20'd65528, '0);

        pool_set[0] = 19'd262144;
        pool_set[1] = 19'h7FFFF;
        pool_set[2] = 19'd0;
        pool_set[3] = 19'd31;
        pool_set[4] = 19'd32;
        pool_set[5] = 19'd100000;
        pool_set[6] = 19'd262112;
        pool_set[7] = 19'($urandom_range(0, 19'h7FFFF));
        pool_set[8] = 19'd4096;

        // random phases, one pool size each
        for (int p = 0; p < 9; p++)
        begin
            write_pool(pool_set[p]);
            send_item(MODE_REBUILD, 20'($urandom), 18'($urandom));
            for (int i = 0; i < 190; i++)
            begin
                if (i % 30 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 39) == 0)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[buddy_block_allocator_core] OK");
        else
            $display("[buddy_block_allocator_core] ERROR");
        $finish;
    end

endmodule
